[sv/asfd_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and codes for the audio sample fifo down-converter
package asfd_pkg;

	// depth must be a power of two; pointers carry one extra wrap bit
	localparam int FIFO_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(FIFO_DEPTH);
	localparam int PTR_W      = ADDR_W + 1;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 6;
	localparam int FILL_W   = 11;
	localparam int SUM_W    = SAMPLE_W + 1;
	localparam int CODE_W   = SUM_W - 9;

	localparam logic [LEVEL_W-1:0] LEVEL_MID = LEVEL_W'(32);
	localparam logic signed [CODE_W-1:0] CODE_MIN = -CODE_W'(32);
	localparam logic signed [CODE_W-1:0] CODE_MAX = CODE_W'(31);
	localparam logic signed [CODE_W-1:0] CODE_OFS = CODE_W'(32);

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// one classified item as it waits between front and back
	typedef struct packed {
		logic               action;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

endpackage

[sv/asfd_front.sv]
`timescale 1ns / 1ps
// front end: takes commands, holds the mode register, converts samples to levels
module asfd_front import asfd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       q_full,
	input  logic                       action,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       last_in_batch,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	output logic                       busy,
	output logic                       push,
	output item_t                      item
);

	logic                     stereo_q;
	logic signed [SUM_W-1:0]  sum;
	logic signed [CODE_W-1:0] code;
	logic signed [CODE_W-1:0] clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b0;
		end else if (cfg_we) begin
			stereo_q <= cfg_wdata;
		end
	end

	// mono shift by 8 is the doubled sample shifted by 9
	always_comb begin
		if (stereo_q) begin
			sum = SUM_W'(left_sample) + SUM_W'(right_sample);
		end else begin
			sum = {left_sample, 1'b0};
		end
		code = sum[SUM_W-1:9];
		if (code < CODE_MIN) begin
			clamped = CODE_MIN;
		end else if (code > CODE_MAX) begin
			clamped = CODE_MAX;
		end else begin
			clamped = code;
		end
	end

	assign busy        = q_full;
	assign push        = start && !q_full;
	assign item.action = action;
	assign item.level  = LEVEL_W'(clamped + CODE_OFS);
	assign item.last   = last_in_batch;

endmodule

[sv/asfd_queue.sv]
`timescale 1ns / 1ps
// two-entry queue between front and back end
module asfd_queue import asfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  item,
	input  logic   pop,
	output logic   full,
	output qhead_t head
);

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign full       = count_q[1];
	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_q];

endmodule

[sv/asfd_back.sv]
`timescale 1ns / 1ps
// back end: level store, pointers, batch drop and registered results
module asfd_back import asfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  qhead_t             head,
	output logic               pop,
	output logic               done,
	output logic [LEVEL_W-1:0] level,
	output logic               level_valid,
	output logic               accepted,
	output logic [FILL_W-1:0]  fill_count
);

	localparam logic ST_EXEC = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic [LEVEL_W-1:0] mem [FIFO_DEPTH];
	logic [LEVEL_W-1:0] rd_data_q;

	logic               state_q;
	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   rp_q;
	logic [LEVEL_W-1:0] held_q;
	logic               drop_q;

	logic [PTR_W-1:0] fill;
	logic [PTR_W-1:0] fill_after_wr;
	logic             is_full;
	logic             do_write;
	logic             do_read;

	assign fill          = wp_q - rp_q;
	assign fill_after_wr = fill + PTR_W'(1);
	assign is_full       = fill[PTR_W-1];
	assign pop           = (state_q == ST_EXEC) && head.valid;
	assign do_write      = pop && head.item.action == ACT_PUSH && !drop_q && !is_full;
	assign do_read       = pop && head.item.action == ACT_TICK && fill != '0;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wp_q[ADDR_W-1:0]] <= head.item.level;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			rd_data_q <= mem[rp_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXEC;
			wp_q        <= '0;
			rp_q        <= '0;
			held_q      <= LEVEL_MID;
			drop_q      <= 1'b0;
			done        <= 1'b0;
			level       <= '0;
			level_valid <= 1'b0;
			accepted    <= 1'b0;
			fill_count  <= '0;
		end else begin
			done        <= 1'b0;
			level       <= '0;
			level_valid <= 1'b0;
			accepted    <= 1'b0;
			unique case (state_q)
				ST_EXEC: begin
					if (pop) begin
						if (head.item.action == ACT_TICK) begin
							if (do_read) begin
								rp_q    <= rp_q + PTR_W'(1);
								state_q <= ST_READ;
							end else begin
								// underrun repeats the held level
								done        <= 1'b1;
								level       <= held_q;
								level_valid <= 1'b1;
								fill_count  <= FILL_W'(fill);
							end
						end else begin
							done <= 1'b1;
							if (drop_q) begin
								if (head.item.last) begin
									drop_q <= 1'b0;
								end
								fill_count <= FILL_W'(fill);
							end else if (is_full) begin
								if (!head.item.last) begin
									drop_q <= 1'b1;
								end
								fill_count <= FILL_W'(fill);
							end else begin
								wp_q       <= wp_q + PTR_W'(1);
								accepted   <= 1'b1;
								fill_count <= FILL_W'(fill_after_wr);
							end
						end
					end
				end
				ST_READ: begin
					held_q      <= rd_data_q;
					done        <= 1'b1;
					level       <= rd_data_q;
					level_valid <= 1'b1;
					fill_count  <= FILL_W'(fill);
					state_q     <= ST_EXEC;
				end
				default: begin
					state_q <= ST_EXEC;
				end
			endcase
		end
	end

endmodule

[sv/audio_sample_fifo_downconvert.sv]
`timescale 1ns / 1ps
// audio sample fifo with 16-bit pcm to 6-bit level conversion
// a push or underrun tick answers from the exec state, a read tick from the read state
// throughput: one push per cycle while busy is low; a popped tick holds the back end in
// read state for the store read, and busy rises when the two-entry queue fills behind it
// the receiver cannot stall: each result shows for one cycle with done high
// reset: asynchronous, clears pointers, batch drop and mode; held level returns to 32
module audio_sample_fifo_downconvert import asfd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       action,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       last_in_batch,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	output logic                       done,
	output logic [LEVEL_W-1:0]         level,
	output logic                       level_valid,
	output logic                       accepted,
	output logic [FILL_W-1:0]          fill_count
);

	logic   q_full;
	logic   push;
	logic   pop;
	item_t  item;
	qhead_t head;

	asfd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.q_full        (q_full),
		.action        (action),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.last_in_batch (last_in_batch),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.busy          (busy),
		.push          (push),
		.item          (item)
	);

	asfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	asfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.done        (done),
		.level       (level),
		.level_valid (level_valid),
		.accepted    (accepted),
		.fill_count  (fill_count)
	);

endmodule

[sv/asfd_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the audio sample fifo, bound to the top level
module asfd_props import asfd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               done,
	input logic [LEVEL_W-1:0] level,
	input logic               level_valid,
	input logic               accepted,
	input logic [FILL_W-1:0]  fill_count
);

	// a transaction is either a tick result or a push result
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(level_valid && accepted))
		else $error("tick and push flags both set");

	a_push_level: assert property (@(posedge clk) disable iff (!arst_n)
		done && !level_valid |-> level == '0)
		else $error("push result carries a level");

	a_acc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> fill_count != '0)
		else $error("stored sample but fifo reports empty");

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fill_count <= FILL_W'(FIFO_DEPTH))
		else $error("fill count beyond depth");

	a_no_flag_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !level_valid && !accepted)
		else $error("result flags without done");

endmodule

bind audio_sample_fifo_downconvert asfd_props u_asfd_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.done        (done),
	.level       (level),
	.level_valid (level_valid),
	.accepted    (accepted),
	.fill_count  (fill_count)
);
